FILE: src/bap_pkg.sv
package bap_pkg;

   typedef enum logic [2:0] {
      ACT_MAINTAIN    = 3'd0,
      ACT_EMERGENCY   = 3'd1,
      ACT_DEC_BITRATE = 3'd2,
      ACT_INC_BITRATE = 3'd3,
      ACT_DEC_RES     = 3'd4,
      ACT_INC_RES     = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      CSR_COOLDOWN     = 2'd0,
      CSR_MIN_THROTTLE = 2'd1,
      CSR_MAX_BITRATE  = 2'd2
   } csr_index_type;

   localparam int TS_W    = 32;
   localparam int RATE_W  = 20;
   localparam int DIM_W   = 13;
   localparam int FPS_W   = 8;
   localparam int CPLX_W  = 9;
   localparam int MS_W    = 16;
   localparam int LOSS_W  = 16;
   localparam int ACT_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [MS_W-1:0]   COOLDOWN_RST     = 16'd2000;
   localparam logic [RATE_W-1:0] MIN_THROTTLE_RST = 20'd500;
   localparam logic [RATE_W-1:0] MAX_BITRATE_RST  = 20'd30000;

   localparam logic [LOSS_W-1:0] LOSS_EMERG   = 16'd9830;
   localparam logic [MS_W-1:0]   RTT_EMERG    = 16'd250;
   localparam logic [LOSS_W-1:0] LOSS_DEC     = 16'd1310;
   localparam logic [LOSS_W-1:0] PLOSS_GOOD   = 16'd328;
   localparam logic [MS_W-1:0]   PRTT_GOOD    = 16'd50;
   localparam logic [LOSS_W-1:0] MLOSS_GOOD   = 16'd66;

   localparam logic [RATE_W-1:0] RATE_LOW     = 20'd2500;
   localparam logic [RATE_W-1:0] RATE_HD      = 20'd6000;
   localparam logic [RATE_W-1:0] RATE_UHD     = 20'd12000;

   localparam logic [DIM_W-1:0]  SD_WIDTH     = 13'd854;
   localparam logic [DIM_W-1:0]  SD_HEIGHT    = 13'd480;
   localparam logic [FPS_W-1:0]  SD_FPS       = 8'd30;
   localparam logic [DIM_W-1:0]  HD_WIDTH     = 13'd1920;
   localparam logic [DIM_W-1:0]  HD_HEIGHT    = 13'd1080;
   localparam logic [FPS_W-1:0]  HD_FPS       = 8'd60;
   localparam logic [DIM_W-1:0]  UHD_WIDTH    = 13'd3840;
   localparam logic [DIM_W-1:0]  UHD_HEIGHT   = 13'd2160;

   // floor(x/5) = (x * DIV5_MULT) >> DIV5_SHIFT, exact for x < 2^22
   localparam int DIV5_SHIFT = 25;
   localparam logic [22:0] DIV5_MULT = 23'd6710887;

endpackage

FILE: src/bitrate_adaptation_policy_unit.sv
// channel   | valid     | ready     | payload
// request   | req_valid | req_ready | req_now_ms .. req_predicted_rtt_ms
// response  | rsp_valid | rsp_ready | rsp_action .. rsp_target_fps
// csr write | csr_valid | csr_ready | csr_index, csr_wdata
//
// One request per cycle sustained while responses are taken; an accepted request goes into the
// input register, then through decision logic into the response register.
// The only loop is the last-action timestamp, updated at the same edge as the response.
// Synchronous active-high reset clears valids, CSRs to defaults, last action time to 0.
// A stalled response holds the input register; requests are taken while it has room.
// csr_ready is always high.
module bitrate_adaptation_policy_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bap_pkg::TS_W-1:0]          req_now_ms,
   input  logic [bap_pkg::RATE_W-1:0]        req_cur_bitrate_kbps,
   input  logic [bap_pkg::DIM_W-1:0]         req_cur_width,
   input  logic [bap_pkg::DIM_W-1:0]         req_cur_height,
   input  logic [bap_pkg::FPS_W-1:0]         req_cur_fps,
   input  logic [bap_pkg::CPLX_W-1:0]        req_scene_complexity,
   input  logic [bap_pkg::MS_W-1:0]          req_measured_rtt_ms,
   input  logic [bap_pkg::LOSS_W-1:0]        req_measured_loss,
   input  logic [bap_pkg::LOSS_W-1:0]        req_predicted_loss,
   input  logic [bap_pkg::MS_W-1:0]          req_predicted_rtt_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bap_pkg::ACT_W-1:0]         rsp_action,
   output logic [bap_pkg::RATE_W-1:0]        rsp_target_bitrate_kbps,
   output logic [bap_pkg::DIM_W-1:0]         rsp_target_width,
   output logic [bap_pkg::DIM_W-1:0]         rsp_target_height,
   output logic [bap_pkg::FPS_W-1:0]         rsp_target_fps,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bap_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bap_pkg::*;

   logic                in_valid_ff;
   logic [TS_W-1:0]     now_ff;
   logic [RATE_W-1:0]   cur_ff;
   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic [FPS_W-1:0]    fps_ff;
   logic [CPLX_W-1:0]   cplx_ff;
   logic [MS_W-1:0]     mrtt_ff;
   logic [LOSS_W-1:0]   mloss_ff;
   logic [LOSS_W-1:0]   ploss_ff;
   logic [MS_W-1:0]     prtt_ff;

   logic [MS_W-1:0]     cooldown_ff;
   logic [RATE_W-1:0]   min_throttle_ff;
   logic [RATE_W-1:0]   max_bitrate_ff;
   logic [TS_W-1:0]     last_action_ff;

   logic                rsp_valid_ff;
   action_type          rsp_action_ff;
   logic [RATE_W-1:0]   rsp_rate_ff;
   logic [DIM_W-1:0]    rsp_width_ff;
   logic [DIM_W-1:0]    rsp_height_ff;
   logic [FPS_W-1:0]    rsp_fps_ff;

   logic                advance;
   logic                take_req;

   action_type          action_in;
   logic [RATE_W-1:0]   rate_in;
   logic [DIM_W-1:0]    width_in;
   logic [DIM_W-1:0]    height_in;
   logic [FPS_W-1:0]    fps_in;
   logic                stamp_in;

   logic                emerg;
   logic                cool_hold;
   logic                dec_cond;
   logic                good_cond;
   logic [TS_W-1:0]     elapsed;
   logic [RATE_W-1:0]   half_rate;
   logic [RATE_W-1:0]   throttle_rate;
   logic [44:0]         dec_prod;
   logic [RATE_W-1:0]   dec_rate;
   logic [29:0]         ideal_prod;
   logic [RATE_W:0]     ideal_rate;
   logic [RATE_W-1:0]   inc_rate;
   logic [18:0]         prtt_x5;
   logic [18:0]         mrtt_x6;
   logic [RATE_W-1:0]   bit_rate;
   action_type          bit_action;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign elapsed    = now_ff - last_action_ff;
   assign emerg      = (ploss_ff > LOSS_EMERG) || (prtt_ff > RTT_EMERG);
   assign cool_hold  = elapsed < {{(TS_W-MS_W){1'b0}}, cooldown_ff};
   assign prtt_x5    = {1'b0, prtt_ff, 2'b00} + {3'b000, prtt_ff};
   assign mrtt_x6    = {1'b0, mrtt_ff, 2'b00} + {2'b00, mrtt_ff, 1'b0};
   assign dec_cond   = (ploss_ff > LOSS_DEC) || (prtt_x5 > mrtt_x6);
   assign good_cond  = (ploss_ff < PLOSS_GOOD) && (prtt_ff < PRTT_GOOD)
                       && (mloss_ff < MLOSS_GOOD);

   assign half_rate     = {1'b0, cur_ff[RATE_W-1:1]};
   assign throttle_rate = (half_rate > min_throttle_ff) ? half_rate : min_throttle_ff;
   assign dec_prod      = {cur_ff, 2'b00} * DIV5_MULT;
   assign dec_rate      = dec_prod[DIV5_SHIFT+RATE_W-1:DIV5_SHIFT];
   assign ideal_prod    = cur_ff * ({1'b0, cplx_ff} + 10'd512);
   assign ideal_rate    = ideal_prod[29:9];
   assign inc_rate      = (ideal_rate < {1'b0, max_bitrate_ff}) ? ideal_rate[RATE_W-1:0]
                                                                 : max_bitrate_ff;

   always_comb begin
      bit_action = ACT_MAINTAIN;
      bit_rate   = cur_ff;
      stamp_in   = 1'b0;
      if (dec_cond) begin
         bit_action = ACT_DEC_BITRATE;
         bit_rate   = dec_rate;
         stamp_in   = 1'b1;
      end else if (good_cond && (cur_ff < max_bitrate_ff)) begin
         bit_action = ACT_INC_BITRATE;
         bit_rate   = inc_rate;
         stamp_in   = 1'b1;
      end

      action_in = bit_action;
      rate_in   = bit_rate;
      width_in  = width_ff;
      height_in = height_ff;
      fps_in    = fps_ff;

      if (emerg) begin
         action_in = ACT_EMERGENCY;
         rate_in   = throttle_rate;
         width_in  = SD_WIDTH;
         height_in = SD_HEIGHT;
         fps_in    = SD_FPS;
         stamp_in  = 1'b1;
      end else if (cool_hold) begin
         action_in = ACT_MAINTAIN;
         rate_in   = cur_ff;
         stamp_in  = 1'b0;
      end else if ((bit_rate < RATE_LOW) && (width_ff > SD_WIDTH)) begin
         action_in = ACT_DEC_RES;
         width_in  = SD_WIDTH;
         height_in = SD_HEIGHT;
         fps_in    = SD_FPS;
      end else if ((bit_rate > RATE_UHD) && (width_ff < UHD_WIDTH)
                   && (width_ff >= HD_WIDTH)) begin
         action_in = ACT_INC_RES;
         width_in  = UHD_WIDTH;
         height_in = UHD_HEIGHT;
      end else if ((bit_rate > RATE_HD) && (width_ff < HD_WIDTH)) begin
         action_in = ACT_INC_RES;
         width_in  = HD_WIDTH;
         height_in = HD_HEIGHT;
         fps_in    = HD_FPS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         now_ff    <= req_now_ms;
         cur_ff    <= req_cur_bitrate_kbps;
         width_ff  <= req_cur_width;
         height_ff <= req_cur_height;
         fps_ff    <= req_cur_fps;
         cplx_ff   <= req_scene_complexity;
         mrtt_ff   <= req_measured_rtt_ms;
         mloss_ff  <= req_measured_loss;
         ploss_ff  <= req_predicted_loss;
         prtt_ff   <= req_predicted_rtt_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooldown_ff     <= COOLDOWN_RST;
         min_throttle_ff <= MIN_THROTTLE_RST;
         max_bitrate_ff  <= MAX_BITRATE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COOLDOWN:     cooldown_ff     <= csr_wdata[MS_W-1:0];
            CSR_MIN_THROTTLE: min_throttle_ff <= csr_wdata[RATE_W-1:0];
            CSR_MAX_BITRATE:  max_bitrate_ff  <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_action_ff <= '0;
      end else if (advance && stamp_in) begin
         last_action_ff <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= action_in;
         rsp_rate_ff   <= rate_in;
         rsp_width_ff  <= width_in;
         rsp_height_ff <= height_in;
         rsp_fps_ff    <= fps_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_action              = rsp_action_ff;
   assign rsp_target_bitrate_kbps = rsp_rate_ff;
   assign rsp_target_width        = rsp_width_ff;
   assign rsp_target_height       = rsp_height_ff;
   assign rsp_target_fps          = rsp_fps_ff;

`ifndef SYNTH
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> rsp_valid_ff && !rsp_ready)
      else $error("input register stalled with room downstream");

   a_emerg_stamp: assert property (@(posedge clock) disable iff (reset)
      advance && emerg |=> last_action_ff == $past(now_ff))
      else $error("emergency did not record action time");

   a_hold_no_stamp: assert property (@(posedge clock) disable iff (reset)
      advance && !emerg && cool_hold |-> action_in == ACT_MAINTAIN && !stamp_in)
      else $error("action taken during cooldown");

   a_emerg_fmt: assert property (@(posedge clock) disable iff (reset)
      advance && emerg |=> rsp_width_ff == SD_WIDTH && rsp_height_ff == SD_HEIGHT
                           && rsp_fps_ff == SD_FPS && rsp_valid_ff)
      else $error("emergency response format wrong");
`endif

endmodule

FILE: tb/sv/bitrate_adaptation_policy_checker.sv
`timescale 1ns / 100ps

module bitrate_adaptation_policy_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [bap_pkg::TS_W-1:0]       req_now_ms,
   input  logic [bap_pkg::RATE_W-1:0]     req_cur_bitrate_kbps,
   input  logic [bap_pkg::DIM_W-1:0]      req_cur_width,
   input  logic [bap_pkg::DIM_W-1:0]      req_cur_height,
   input  logic [bap_pkg::FPS_W-1:0]      req_cur_fps,
   input  logic [bap_pkg::CPLX_W-1:0]     req_scene_complexity,
   input  logic [bap_pkg::MS_W-1:0]       req_measured_rtt_ms,
   input  logic [bap_pkg::LOSS_W-1:0]     req_measured_loss,
   input  logic [bap_pkg::LOSS_W-1:0]     req_predicted_loss,
   input  logic [bap_pkg::MS_W-1:0]       req_predicted_rtt_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [bap_pkg::ACT_W-1:0]      rsp_action,
   input  logic [bap_pkg::RATE_W-1:0]     rsp_target_bitrate_kbps,
   input  logic [bap_pkg::DIM_W-1:0]      rsp_target_width,
   input  logic [bap_pkg::DIM_W-1:0]      rsp_target_height,
   input  logic [bap_pkg::FPS_W-1:0]      rsp_target_fps,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bap_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import bap_pkg::*;

   typedef struct {
      action_type        action;
      logic [RATE_W-1:0] rate;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [FPS_W-1:0]  fps;
   } decision_type;

   decision_type      expected_decisions[$];
   logic [MS_W-1:0]   cooldown;
   logic [RATE_W-1:0] min_throttle;
   logic [RATE_W-1:0] max_bitrate;
   logic [TS_W-1:0]   last_action;

   function automatic decision_type policy_decision(
      input logic [TS_W-1:0]   now,
      input logic [RATE_W-1:0] cur,
      input logic [DIM_W-1:0]  width,
      input logic [DIM_W-1:0]  height,
      input logic [FPS_W-1:0]  fps,
      input logic [CPLX_W-1:0] cplx,
      input logic [MS_W-1:0]   mrtt,
      input logic [LOSS_W-1:0] mloss,
      input logic [LOSS_W-1:0] ploss,
      input logic [MS_W-1:0]   prtt
   );
      decision_type d;
      logic [63:0]  rate;
      logic [63:0]  half;
      logic [63:0]  ideal;
      logic [31:0]  since;
      d.action = ACT_MAINTAIN;
      d.width  = width;
      d.height = height;
      d.fps    = fps;
      rate     = 64'(cur);
      if (ploss > LOSS_EMERG || prtt > RTT_EMERG) begin
         half     = 64'(cur) >> 1;
         rate     = (half > 64'(min_throttle)) ? half : 64'(min_throttle);
         d.action = ACT_EMERGENCY;
         d.width  = SD_WIDTH;
         d.height = SD_HEIGHT;
         d.fps    = SD_FPS;
         last_action = now;
      end else begin
         since = now - last_action;
         if (since >= 32'(cooldown)) begin
            ideal = (64'(cur) * (64'd512 + 64'(cplx))) >> 9;
            if (ploss > LOSS_DEC || 64'd5 * 64'(prtt) > 64'd6 * 64'(mrtt)) begin
               d.action    = ACT_DEC_BITRATE;
               rate        = (64'(cur) * 64'd4) / 64'd5;
               last_action = now;
            end else if (ploss < PLOSS_GOOD && prtt < PRTT_GOOD && mloss < MLOSS_GOOD
                         && 64'(cur) < 64'(max_bitrate)) begin
               d.action    = ACT_INC_BITRATE;
               rate        = (ideal < 64'(max_bitrate)) ? ideal : 64'(max_bitrate);
               last_action = now;
            end
            if (rate < 64'(RATE_LOW) && width > SD_WIDTH) begin
               d.action = ACT_DEC_RES;
               d.width  = SD_WIDTH;
               d.height = SD_HEIGHT;
               d.fps    = SD_FPS;
            end else if (rate > 64'(RATE_UHD) && width < UHD_WIDTH && width >= HD_WIDTH) begin
               d.action = ACT_INC_RES;
               d.width  = UHD_WIDTH;
               d.height = UHD_HEIGHT;
            end else if (rate > 64'(RATE_HD) && width < HD_WIDTH) begin
               d.action = ACT_INC_RES;
               d.width  = HD_WIDTH;
               d.height = HD_HEIGHT;
               d.fps    = HD_FPS;
            end
         end
      end
      if (rate > 64'hFFFFF) rate = 64'hFFFFF;
      d.rate = rate[RATE_W-1:0];
      return d;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         expected_decisions.delete();
         cooldown     = COOLDOWN_RST;
         min_throttle = MIN_THROTTLE_RST;
         max_bitrate  = MAX_BITRATE_RST;
         last_action  = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COOLDOWN:     cooldown     = csr_wdata[MS_W-1:0];
               CSR_MIN_THROTTLE: min_throttle = csr_wdata[RATE_W-1:0];
               CSR_MAX_BITRATE:  max_bitrate  = csr_wdata[RATE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_decisions.push_back(policy_decision(req_now_ms, req_cur_bitrate_kbps,
               req_cur_width, req_cur_height, req_cur_fps, req_scene_complexity,
               req_measured_rtt_ms, req_measured_loss, req_predicted_loss,
               req_predicted_rtt_ms));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decisions.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual action %0d",
                        $time, rsp_action);
               fail_count++;
            end else begin
               want = expected_decisions.pop_front();
               check_field("action", 32'(want.action), 32'(rsp_action));
               check_field("target_bitrate_kbps", 32'(want.rate), 32'(rsp_target_bitrate_kbps));
               check_field("target_width", 32'(want.width), 32'(rsp_target_width));
               check_field("target_height", 32'(want.height), 32'(rsp_target_height));
               check_field("target_fps", 32'(want.fps), 32'(rsp_target_fps));
            end
         end
      end
      pending = expected_decisions.size();
   end

endmodule

FILE: tb/sv/bitrate_adaptation_policy_unit_test.sv
`timescale 1ns / 100ps

module bitrate_adaptation_policy_unit_test;
   import bap_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int PHASE_COUNT   = 5;
   localparam int PHASE_ITEMS   = 400;
   localparam int CHOKE_CYCLES  = 64;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [TS_W-1:0]       req_now_ms;
   logic [RATE_W-1:0]     req_cur_bitrate_kbps;
   logic [DIM_W-1:0]      req_cur_width;
   logic [DIM_W-1:0]      req_cur_height;
   logic [FPS_W-1:0]      req_cur_fps;
   logic [CPLX_W-1:0]     req_scene_complexity;
   logic [MS_W-1:0]       req_measured_rtt_ms;
   logic [LOSS_W-1:0]     req_measured_loss;
   logic [LOSS_W-1:0]     req_predicted_loss;
   logic [MS_W-1:0]       req_predicted_rtt_ms;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [ACT_W-1:0]      rsp_action;
   logic [RATE_W-1:0]     rsp_target_bitrate_kbps;
   logic [DIM_W-1:0]      rsp_target_width;
   logic [DIM_W-1:0]      rsp_target_height;
   logic [FPS_W-1:0]      rsp_target_fps;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int          fail_count;
   int          outstanding;
   logic        calm;
   logic        choke_go;
   logic        choke_done;
   logic [31:0] stamp;

   bitrate_adaptation_policy_unit u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_now_ms              (req_now_ms),
      .req_cur_bitrate_kbps    (req_cur_bitrate_kbps),
      .req_cur_width           (req_cur_width),
      .req_cur_height          (req_cur_height),
      .req_cur_fps             (req_cur_fps),
      .req_scene_complexity    (req_scene_complexity),
      .req_measured_rtt_ms     (req_measured_rtt_ms),
      .req_measured_loss       (req_measured_loss),
      .req_predicted_loss      (req_predicted_loss),
      .req_predicted_rtt_ms    (req_predicted_rtt_ms),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_action              (rsp_action),
      .rsp_target_bitrate_kbps (rsp_target_bitrate_kbps),
      .rsp_target_width        (rsp_target_width),
      .rsp_target_height       (rsp_target_height),
      .rsp_target_fps          (rsp_target_fps),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   bitrate_adaptation_policy_checker u_check (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_now_ms              (req_now_ms),
      .req_cur_bitrate_kbps    (req_cur_bitrate_kbps),
      .req_cur_width           (req_cur_width),
      .req_cur_height          (req_cur_height),
      .req_cur_fps             (req_cur_fps),
      .req_scene_complexity    (req_scene_complexity),
      .req_measured_rtt_ms     (req_measured_rtt_ms),
      .req_measured_loss       (req_measured_loss),
      .req_predicted_loss      (req_predicted_loss),
      .req_predicted_rtt_ms    (req_predicted_rtt_ms),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_action              (rsp_action),
      .rsp_target_bitrate_kbps (rsp_target_bitrate_kbps),
      .rsp_target_width        (rsp_target_width),
      .rsp_target_height       (rsp_target_height),
      .rsp_target_fps          (rsp_target_fps),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .fail_count              (fail_count),
      .pending                 (outstanding)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic send_report(
      input logic [TS_W-1:0]   now,
      input logic [RATE_W-1:0] cur,
      input logic [DIM_W-1:0]  width,
      input logic [DIM_W-1:0]  height,
      input logic [FPS_W-1:0]  fps,
      input logic [CPLX_W-1:0] cplx,
      input logic [MS_W-1:0]   mrtt,
      input logic [LOSS_W-1:0] mloss,
      input logic [LOSS_W-1:0] ploss,
      input logic [MS_W-1:0]   prtt
   );
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_now_ms           <= now;
      req_cur_bitrate_kbps <= cur;
      req_cur_width        <= width;
      req_cur_height       <= height;
      req_cur_fps          <= fps;
      req_scene_complexity <= cplx;
      req_measured_rtt_ms  <= mrtt;
      req_measured_loss    <= mloss;
      req_predicted_loss   <= ploss;
      req_predicted_rtt_ms <= prtt;
      req_valid            <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random_report();
      logic [RATE_W-1:0] cur;
      logic [DIM_W-1:0]  width;
      logic [CPLX_W-1:0] cplx;
      logic [MS_W-1:0]   mrtt;
      logic [LOSS_W-1:0] mloss;
      logic [LOSS_W-1:0] ploss;
      logic [MS_W-1:0]   prtt;
      int                kind;
      case ($urandom_range(19))
         0:       stamp = $urandom;
         1, 2:    stamp = stamp + $urandom_range(0, 140000);
         default: stamp = stamp + $urandom_range(0, 4000);
      endcase
      case ($urandom_range(5))
         0:       cur = RATE_W'($urandom_range(0, 1023));
         1:       cur = RATE_W'($urandom_range(2000, 3200));
         2:       cur = RATE_W'($urandom_range(5000, 15500));
         3:       cur = RATE_W'($urandom_range(20000, 40000));
         4:       cur = RATE_W'($urandom);
         default: cur = RATE_W'($urandom_range(0, 35000));
      endcase
      case ($urandom_range(7))
         0:       width = SD_WIDTH;
         1:       width = SD_WIDTH + 13'd1;
         2:       width = 13'd1280;
         3:       width = HD_WIDTH - 13'd1;
         4:       width = HD_WIDTH;
         5:       width = UHD_WIDTH - 13'd1;
         6:       width = UHD_WIDTH;
         default: width = DIM_W'($urandom);
      endcase
      cplx  = ($urandom_range(9) < 7) ? CPLX_W'($urandom_range(0, 256)) : CPLX_W'($urandom);
      mrtt  = MS_W'($urandom);
      mloss = LOSS_W'($urandom);
      ploss = LOSS_W'($urandom);
      prtt  = MS_W'($urandom);
      kind  = $urandom_range(99);
      if (kind < 12) begin
         if ($urandom_range(1) == 1) begin
            ploss = LOSS_W'($urandom_range(9831, 65535));
         end else begin
            ploss = LOSS_W'($urandom_range(0, 9830));
            prtt  = MS_W'($urandom_range(251, 65535));
         end
      end else if (kind < 40) begin
         prtt = MS_W'($urandom_range(0, 250));
         if ($urandom_range(1) == 1) begin
            ploss = LOSS_W'($urandom_range(1311, 9830));
         end else begin
            ploss = LOSS_W'($urandom_range(0, 1310));
            prtt  = MS_W'($urandom_range(1, 250));
            mrtt  = MS_W'($urandom_range(0, (5 * prtt - 1) / 6));
         end
      end else if (kind < 80) begin
         ploss = LOSS_W'($urandom_range(0, 327));
         prtt  = MS_W'($urandom_range(0, 49));
         mloss = LOSS_W'($urandom_range(0, 65));
         mrtt  = MS_W'($urandom_range(prtt, 65535));
      end
      send_report(stamp, cur, width, DIM_W'($urandom), FPS_W'($urandom), cplx,
                  mrtt, mloss, ploss, prtt);
   endtask

   // leaves csr_valid high; the caller drops it once after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int k;
      rsp_ready  = 1'b0;
      choke_done = 1'b0;
      forever begin
         @(negedge clock);
         if (choke_go && !choke_done) begin
            choke_done = 1'b1;
            rsp_ready <= 1'b0;
            for (k = 0; k < CHOKE_CYCLES; k++) @(negedge clock);
         end
         rsp_ready <= calm || $urandom_range(99) >= 22;
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int phase;
      int n;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_now_ms           = '0;
      req_cur_bitrate_kbps = '0;
      req_cur_width        = '0;
      req_cur_height       = '0;
      req_cur_fps          = '0;
      req_scene_complexity = '0;
      req_measured_rtt_ms  = '0;
      req_measured_loss    = '0;
      req_predicted_loss   = '0;
      req_predicted_rtt_ms = '0;
      csr_valid            = 1'b0;
      csr_index            = CSR_COOLDOWN;
      csr_wdata            = '0;
      calm                 = 1'b0;
      choke_go             = 1'b0;
      stamp                = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset settings: cooldown hold, wrap, every action and threshold edge
      send_report(32'd100, 20'd5000, 13'd1280, 13'd720, 8'd30, 9'd128, 16'd40, 16'd0,
                  16'd0, 16'd10);
      send_report(32'hFFFF_FFFF, 20'hFFFFF, 13'd1920, 13'd1080, 8'd60, 9'd0, 16'd20, 16'd0,
                  16'd9831, 16'd0);
      send_report(32'd1500, 20'd8000, 13'd1920, 13'd1080, 8'd60, 9'd100, 16'd50, 16'd10,
                  16'd100, 16'd20);
      send_report(32'd2000, 20'd3000, 13'd1280, 13'd720, 8'd30, 9'd0, 16'd100, 16'd0,
                  16'd0, 16'd121);
      send_report(32'd2001, 20'd600, 13'd640, 13'd360, 8'd25, 9'd0, 16'd0, 16'd0,
                  16'd0, 16'd251);
      send_report(32'd4001, 20'd29999, 13'd2000, 13'd1125, 8'd50, 9'd511, 16'd60, 16'd65,
                  16'd327, 16'd49);
      send_report(32'd6001, 20'd7000, 13'd1280, 13'd720, 8'd30, 9'd0, 16'd10, 16'd0,
                  16'd0, 16'd0);
      send_report(32'd8001, 20'd30000, 13'd3839, 13'd2160, 8'd30, 9'd256, 16'd10, 16'd0,
                  16'd0, 16'd0);
      send_report(32'd10001, 20'd20000, 13'd854, 13'd480, 8'd30, 9'd0, 16'd300, 16'd0,
                  16'd9830, 16'd250);
      send_report(32'd12000, 20'd2000, 13'd854, 13'd480, 8'd24, 9'd0, 16'd0, 16'd0,
                  16'd1310, 16'd0);
      send_report(32'd12001, 20'd2000, 13'd854, 13'd480, 8'd24, 9'd0, 16'd0, 16'd0,
                  16'd1310, 16'd0);
      send_report(32'hFFFF_FFFF, 20'hFFFFF, 13'h1FFF, 13'h1FFF, 8'hFF, 9'h1FF, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_report(32'd0, 20'd0, 13'd0, 13'd0, 8'd0, 9'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_report(32'd3000, 20'd100000, 13'd3840, 13'd2160, 8'd60, 9'd256, 16'd100, 16'd100,
                  16'd400, 16'd100);
      send_report(32'd6000, 20'd1000000, 13'd1919, 13'd1080, 8'd30, 9'd300, 16'd1000, 16'd0,
                  16'd0, 16'd0);
      send_report(32'd9000, 20'd2499, 13'd855, 13'd480, 8'd30, 9'd0, 16'd0, 16'd66,
                  16'd0, 16'd0);
      send_report(32'd12000, 20'd12001, 13'd1920, 13'd1080, 8'd30, 9'd0, 16'd0, 16'd0,
                  16'd0, 16'd0);
      drain();

      stamp = $urandom;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_COOLDOWN, 20'd0);
               write_reg(CSR_MIN_THROTTLE, 20'd0);
               write_reg(CSR_MAX_BITRATE, 20'hFFFFF);
            end
            1: begin
               write_reg(CSR_COOLDOWN, 20'hFFFFF);
               write_reg(CSR_MIN_THROTTLE, 20'hFFFFF);
               write_reg(CSR_MAX_BITRATE, 20'd0);
            end
            3: begin
               write_reg(CSR_COOLDOWN, 20'(COOLDOWN_RST));
               write_reg(CSR_MIN_THROTTLE, MIN_THROTTLE_RST);
               write_reg(CSR_MAX_BITRATE, MAX_BITRATE_RST);
            end
            default: begin
               write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
               write_reg(CSR_COOLDOWN, 20'($urandom_range(0, 5000)));
               write_reg(CSR_MIN_THROTTLE, CSR_DATA_W'($urandom_range(0, 20000)));
               write_reg(CSR_MAX_BITRATE, CSR_DATA_W'($urandom_range(1000, 60000)));
            end
         endcase
         csr_valid <= 1'b0;
         if (phase == 3) choke_go = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            calm = (phase == 2) && (n >= 100) && (n < 300);
            send_random_report();
         end
         calm = 1'b0;
         drain();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
